FILE: src/memory_map_region_picker_top_defines.svh
// Assertion macros for the memory map region picker.
// Taken in by `include in the RTL files that carry assertions; no other dependencies.
`ifndef MEMORY_MAP_REGION_PICKER_TOP_DEFINES_SVH
`define MEMORY_MAP_REGION_PICKER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MMRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mmrp: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MMRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mmrp: next-cycle check failed");

`endif

FILE: src/mmrp_pkg.sv
// Constants and payload types for the memory map region picker.
// No dependencies; used by the channel interfaces and the top level.
package mmrp_pkg;

    localparam logic [63:0] REGION_BYTES   = 64'd134217728;
    localparam logic [31:0] AVAILABLE_CODE = 32'd1;

    // Highest base that still leaves room for one window below 4 GiB (32-bit wrap).
    localparam logic [31:0] REGION_LO_MAX = 32'hFFFF_FFFF - REGION_BYTES[31:0] + 32'd1;
    localparam logic [31:0] REGION_M1     = REGION_BYTES[31:0] - 32'd1;

    // 4 MiB alignment: low bits inside a granule, high bits select it.
    localparam int ALIGN_BITS = 22;
    localparam int GRAN_BITS  = 32 - ALIGN_BITS;

    localparam logic [31:0] SIXTEEN_MIB = 32'h0100_0000;
    localparam logic [13:0] KIB_CAP     = 14'h3C00;
    localparam int          KIB_SHIFT   = 10;
    localparam int          BLOCK_SHIFT = 16;

    typedef struct packed {
        logic [63:0] entry_base;
        logic [63:0] entry_length;
        logic [31:0] entry_kind;
        logic        final_entry;
    } t_entry;

    typedef struct packed {
        logic [31:0] chosen_start;
        logic [63:0] total_available;
        logic [63:0] carved_base;
        logic [63:0] carved_short_length;
        logic [63:0] reserved_size;
        logic [63:0] carved_end;
        logic [13:0] kib_low_word;
        logic [15:0] blocks_high_word;
    } t_result;

endpackage

FILE: src/mmrp_entry_if.sv
// Valid/ready channel carrying one memory map entry.
// Depends on mmrp_pkg for the entry payload type.
interface mmrp_entry_if;
    import mmrp_pkg::*;

    logic   valid;
    logic   ready;
    t_entry data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/mmrp_result_if.sv
// Valid/ready channel carrying one scan result.
// Depends on mmrp_pkg for the result payload type.
interface mmrp_result_if;
    import mmrp_pkg::*;

    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/memory_map_region_picker_top.sv
// Memory map region picker: sums available entries and picks the highest window below 4 GiB.
// Depends on mmrp_pkg, mmrp_entry_if, mmrp_result_if and the assertion macro header.
//
//   channel    dir  transfers            payload
//   i_entry    in   one per map entry    t_entry (base, length, kind, final mark)
//   o_result   out  one per final entry  t_result (window, totals, E801 words)
//
// One entry per cycle while the pipeline is not stalled; an entry passes through the input
// register, the end/clip stage and the alignment stage, then updates the scan state, and a
// final entry loads its result into the output register in the same cycle as that update.
// Synchronous active-low reset clears the pipeline valids and the scan state.
// The pipeline stalls as a whole only when a final entry reaches the update stage while
// the output register still holds a result that is not taken.
`include "memory_map_region_picker_top_defines.svh"

module memory_map_region_picker_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mmrp_entry_if.sink    i_entry,
    mmrp_result_if.source o_result
);
    import mmrp_pkg::*;

    logic en;

    // stage 1: registered entry
    logic        r_s1_valid, r_s1_final, r_s1_avail;
    logic [63:0] r_s1_base, r_s1_len;

    // stage 2: last byte, clip and range checks
    logic [63:0] s2_last;
    logic [31:0] s2_lo, s2_hi;
    logic        s2_ok;
    logic        r_s2_valid, r_s2_final, r_s2_avail, r_s2_ok;
    logic [31:0] r_s2_lo, r_s2_hi;
    logic [63:0] r_s2_base, r_s2_len, r_s2_end;

    // stage 3: alignment and candidate
    logic [31:0] s3_lo_a, s3_hi_a, s3_cand;
    logic        s3_fit;
    logic [63:0] s3_short;
    logic        r_s3_valid, r_s3_final, r_s3_avail, r_s3_fit;
    logic [31:0] r_s3_cand;
    logic [63:0] r_s3_base, r_s3_len, r_s3_end, r_s3_short;

    // scan state
    logic [31:0] r_best, n_best;
    logic [63:0] r_total, n_total;
    logic [63:0] r_sel_base, n_sel_base;
    logic [63:0] r_sel_short, n_sel_short;
    logic [63:0] r_sel_reserved, n_sel_reserved;
    logic [63:0] r_sel_end, n_sel_end;
    logic        take;

    // result
    logic [21:0] n_kib_raw;
    logic [13:0] n_kib;
    logic [31:0] n_blk_diff;
    logic [15:0] n_blk;
    logic        r_out_valid;
    t_result     r_out;

    assign en = !(r_s3_valid && r_s3_final && r_out_valid && !o_result.ready);
    assign i_entry.ready = en;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    // stage 2 logic
    always_comb begin
        s2_last = r_s1_base + r_s1_len - 64'd1;
        s2_lo   = r_s1_base[31:0];
        s2_hi   = (s2_last[63:32] != 32'd0) ? 32'hFFFF_FFFF : s2_last[31:0];
        s2_ok   = (r_s1_base[63:32] == 32'd0) && (s2_lo <= s2_hi)
               && (s2_lo <= REGION_LO_MAX) && (s2_hi >= REGION_BYTES[31:0]);
    end

    // stage 3 logic: round low bound up and high bound down to 4 MiB granules
    always_comb begin
        s3_lo_a  = {r_s2_lo[31:ALIGN_BITS]
                    + GRAN_BITS'(r_s2_lo[ALIGN_BITS-1:0] != '0), {ALIGN_BITS{1'b0}}};
        s3_hi_a  = {r_s2_hi[31:ALIGN_BITS]
                    - GRAN_BITS'(r_s2_hi[ALIGN_BITS-1:0] != '1), {ALIGN_BITS{1'b1}}};
        s3_cand  = s3_hi_a - REGION_M1;
        s3_fit   = r_s2_ok && (s3_lo_a <= s3_hi_a) && ((s3_hi_a - s3_lo_a) >= REGION_M1);
        s3_short = {32'd0, s3_cand} - r_s2_base;
    end

    // stage 4 logic: keep only a strictly higher window
    always_comb begin
        take           = r_s3_valid && r_s3_avail && r_s3_fit && (r_best < r_s3_cand);
        n_best         = take ? r_s3_cand : r_best;
        n_sel_base     = take ? r_s3_base : r_sel_base;
        n_sel_short    = take ? r_s3_short : r_sel_short;
        n_sel_reserved = take ? (r_s3_len - r_s3_short) : r_sel_reserved;
        n_sel_end      = take ? r_s3_end : r_sel_end;
        n_total        = (r_s3_valid && r_s3_avail) ? (r_total + r_s3_len) : r_total;

        n_kib_raw  = n_best[31:KIB_SHIFT];
        n_kib      = (n_kib_raw > 22'(KIB_CAP)) ? KIB_CAP : n_kib_raw[13:0];
        n_blk_diff = n_best - SIXTEEN_MIB;
        n_blk      = (n_best > SIXTEEN_MIB) ? n_blk_diff[31:BLOCK_SHIFT] : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_s2_valid     <= 1'b0;
            r_s3_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_best         <= 32'd0;
            r_total        <= 64'd0;
            r_sel_base     <= 64'd0;
            r_sel_short    <= 64'd0;
            r_sel_reserved <= REGION_BYTES;
            r_sel_end      <= 64'd0;
        end else begin
            if (en) begin
                r_s1_valid <= i_entry.valid;
                r_s2_valid <= r_s1_valid;
                r_s3_valid <= r_s2_valid;
                if (r_s3_valid && r_s3_final) begin
                    // close the scan: start the next one from reset values
                    r_best         <= 32'd0;
                    r_total        <= 64'd0;
                    r_sel_base     <= 64'd0;
                    r_sel_short    <= 64'd0;
                    r_sel_reserved <= REGION_BYTES;
                    r_sel_end      <= 64'd0;
                end else begin
                    r_best         <= n_best;
                    r_total        <= n_total;
                    r_sel_base     <= n_sel_base;
                    r_sel_short    <= n_sel_short;
                    r_sel_reserved <= n_sel_reserved;
                    r_sel_end      <= n_sel_end;
                end
            end
            if (en && r_s3_valid && r_s3_final) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_final <= i_entry.data.final_entry;
            r_s1_avail <= (i_entry.data.entry_kind == AVAILABLE_CODE);
            r_s1_base  <= i_entry.data.entry_base;
            r_s1_len   <= i_entry.data.entry_length;

            r_s2_final <= r_s1_final;
            r_s2_avail <= r_s1_avail;
            r_s2_ok    <= s2_ok;
            r_s2_lo    <= s2_lo;
            r_s2_hi    <= s2_hi;
            r_s2_base  <= r_s1_base;
            r_s2_len   <= r_s1_len;
            r_s2_end   <= r_s1_base + r_s1_len;

            r_s3_final <= r_s2_final;
            r_s3_avail <= r_s2_avail;
            r_s3_fit   <= s3_fit;
            r_s3_cand  <= s3_cand;
            r_s3_base  <= r_s2_base;
            r_s3_len   <= r_s2_len;
            r_s3_end   <= r_s2_end;
            r_s3_short <= s3_short;

            if (r_s3_valid && r_s3_final) begin
                r_out.chosen_start        <= n_best;
                r_out.total_available     <= n_total;
                r_out.carved_base         <= n_sel_base;
                r_out.carved_short_length <= n_sel_short;
                r_out.reserved_size       <= n_sel_reserved;
                r_out.carved_end          <= n_sel_end;
                r_out.kib_low_word        <= n_kib;
                r_out.blocks_high_word    <= n_blk;
            end
        end
    end

    // a final entry leaves the scan state at its reset values
    `MMRP_ASSERT_NEXT(a_scan_cleared, i_clk, i_rst_n,
        en && r_s3_valid && r_s3_final,
        r_best == 32'd0 && r_total == 64'd0 && r_sel_reserved == REGION_BYTES)

    // no window chosen means no carved entry was recorded
    `MMRP_ASSERT_NOW(a_none_chosen, i_clk, i_rst_n,
        o_result.valid && o_result.data.chosen_start == 32'd0,
        o_result.data.carved_base == 64'd0 && o_result.data.carved_end == 64'd0
            && o_result.data.reserved_size == REGION_BYTES)

    // the pipeline holds only behind a result that is not taken
    `MMRP_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, !en,
        r_out_valid && !o_result.ready && r_s3_valid && r_s3_final)

    // a window that is held never moves down within a scan
    `MMRP_ASSERT_NEXT(a_best_rises, i_clk, i_rst_n, !(r_s3_valid && r_s3_final),
        r_best >= $past(r_best))

endmodule

FILE: dv/mmrp_region_check_pkg.sv
// Scoreboard for the memory map region picker: tracks the scan state of each map entry
// and checks every scan result against the window it should have chosen.
// Depends on mmrp_pkg for the entry and result types and the block constants.
package mmrp_region_check_pkg;
    import mmrp_pkg::*;

    localparam logic [31:0] WIN_BYTES   = REGION_BYTES[31:0];
    localparam logic [31:0] WIN_LO_MAX  = 32'hFFFF_FFFF - WIN_BYTES + 32'd1;
    localparam logic [31:0] GRAN_MASK   = 32'h003F_FFFF;
    localparam logic [31:0] E801_BASE   = 32'h0100_0000;
    localparam logic [31:0] E801_KIB_MAX = 32'h0000_3C00;

    class region_pick_checker;
        logic [31:0] best_start;
        logic [63:0] running_total;
        logic [63:0] sel_base;
        logic [63:0] sel_short_len;
        logic [63:0] sel_reserved;
        logic [63:0] sel_end;
        t_result     pending_windows[$];
        int unsigned mismatches;

        function new();
            clear_scan();
            mismatches = 0;
        endfunction

        function void clear_scan();
            best_start    = '0;
            running_total = '0;
            sel_base      = '0;
            sel_short_len = '0;
            sel_reserved  = REGION_BYTES;
            sel_end       = '0;
        endfunction

        // Advance the scan by one accepted entry; queue the result on a final entry.
        function void note_entry(t_entry e);
            logic [63:0] last64;
            logic [31:0] lo;
            logic [31:0] hi;
            logic [31:0] cand;
            logic [31:0] kib;
            logic [31:0] blk;
            t_result     r;
            if (e.entry_kind == AVAILABLE_CODE) begin
                running_total = running_total + e.entry_length;
                last64 = e.entry_base + e.entry_length - 64'd1;
                hi = (last64[63:32] != 32'd0) ? 32'hFFFF_FFFF : last64[31:0];
                lo = e.entry_base[31:0];
                if (e.entry_base[63:32] == 32'd0 && lo <= hi && lo <= WIN_LO_MAX
                        && hi >= WIN_BYTES) begin
                    // align inward to 4 MiB, wrapping in 32 bits
                    lo = (lo + GRAN_MASK) & ~GRAN_MASK;
                    hi = ((hi + 32'd1) & ~GRAN_MASK) - 32'd1;
                    cand = hi - (WIN_BYTES - 32'd1);
                    if (lo <= hi && (hi - lo) >= (WIN_BYTES - 32'd1) && best_start < cand) begin
                        best_start    = cand;
                        sel_base      = e.entry_base;
                        sel_short_len = {32'd0, cand} - e.entry_base;
                        sel_reserved  = e.entry_length - sel_short_len;
                        sel_end       = e.entry_base + e.entry_length;
                    end
                end
            end
            if (e.final_entry) begin
                kib = best_start >> KIB_SHIFT;
                if (kib > E801_KIB_MAX)
                    kib = E801_KIB_MAX;
                blk = (best_start > E801_BASE) ? ((best_start - E801_BASE) >> BLOCK_SHIFT) : '0;
                r.chosen_start        = best_start;
                r.total_available     = running_total;
                r.carved_base         = sel_base;
                r.carved_short_length = sel_short_len;
                r.reserved_size       = sel_reserved;
                r.carved_end          = sel_end;
                r.kib_low_word        = kib[13:0];
                r.blocks_high_word    = blk[15:0];
                pending_windows.push_back(r);
                clear_scan();
            end
        endfunction

        function void cmp_field(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %h actual %h", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_result r);
            t_result w;
            if (pending_windows.size() == 0) begin
                $display("%0t: result with no scan outstanding, actual %h", $time, r);
                mismatches++;
                return;
            end
            w = pending_windows.pop_front();
            cmp_field("chosen_start", 64'(w.chosen_start), 64'(r.chosen_start));
            cmp_field("total_available", w.total_available, r.total_available);
            cmp_field("carved_base", w.carved_base, r.carved_base);
            cmp_field("carved_short_length", w.carved_short_length, r.carved_short_length);
            cmp_field("reserved_size", w.reserved_size, r.reserved_size);
            cmp_field("carved_end", w.carved_end, r.carved_end);
            cmp_field("kib_low_word", 64'(w.kib_low_word), 64'(r.kib_low_word));
            cmp_field("blocks_high_word", 64'(w.blocks_high_word), 64'(r.blocks_high_word));
        endfunction

        function int unsigned outstanding();
            return pending_windows.size();
        endfunction
    endclass

endpackage

FILE: dv/memory_map_region_picker_top_tb.sv
// Testbench for memory_map_region_picker_top: directed and random memory map scans,
// random idling on both channels and one long result stall.
// Depends on mmrp_pkg, the channel interfaces and mmrp_region_check_pkg.
module memory_map_region_picker_top_tb;
    import mmrp_pkg::*;
    import mmrp_region_check_pkg::*;

    localparam logic [31:0] KIND_RESERVED     = 32'd2;
    localparam logic [31:0] KIND_ACPI_RECLAIM = 32'd3;
    localparam logic [31:0] KIND_ACPI_NVS     = 32'd4;
    localparam logic [31:0] KIND_UNUSABLE     = 32'd5;
    localparam logic [31:0] KIND_MAX          = 32'hFFFF_FFFF;

    localparam logic [63:0] FOUR_GIB = 64'h1_0000_0000;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam int unsigned RANDOM_ITEMS = 1300;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned HOLD_AFTER   = 30;

    logic i_clk;
    logic i_rst_n;

    mmrp_entry_if  ent_if();
    mmrp_result_if res_if();

    memory_map_region_picker_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (ent_if),
        .o_result (res_if)
    );

    region_pick_checker scan_check;
    int unsigned        items_sent;
    int unsigned        cycle_count = 0;
    bit                 steady_run;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned draw_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_entry mk_entry(logic [63:0] base, logic [63:0] len,
                                        logic [31:0] kind, logic last);
        t_entry e;
        e.entry_base   = base;
        e.entry_length = len;
        e.entry_kind   = kind;
        e.final_entry  = last;
        return e;
    endfunction

    function automatic t_entry rand_entry(logic last);
        t_entry      e;
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 70)
            e.entry_kind = AVAILABLE_CODE;
        else if (p < 85) begin
            case ($urandom_range(0, 3))
                0: e.entry_kind = KIND_RESERVED;
                1: e.entry_kind = KIND_ACPI_RECLAIM;
                2: e.entry_kind = KIND_ACPI_NVS;
                default: e.entry_kind = KIND_UNUSABLE;
            endcase
        end else
            e.entry_kind = $urandom;

        p = $urandom_range(0, 99);
        if (p < 40) begin
            e.entry_base = 64'($urandom_range(0, 1023)) << 22;
            if ($urandom_range(0, 3) == 0)
                e.entry_base[21:0] = 22'($urandom);
        end else if (p < 65)
            e.entry_base = {32'd0, 32'($urandom)};
        else if (p < 80)
            e.entry_base = {32'($urandom), 32'($urandom)};
        else if (p < 90)
            e.entry_base = '0;
        else
            e.entry_base = 64'h0000_0000_F000_0000 + 64'($urandom_range(0, 32'h0FFF_FFFF));

        p = $urandom_range(0, 99);
        if (p < 35) begin
            e.entry_length = 64'($urandom_range(1, 128)) << 22;
            if ($urandom_range(0, 3) == 0)
                e.entry_length[21:0] = 22'($urandom);
        end else if (p < 60)
            e.entry_length = {32'd0, 32'($urandom)};
        else if (p < 70)
            e.entry_length = {32'($urandom), 32'($urandom)};
        else if (p < 80)
            e.entry_length = '0;
        else if (p < 90)
            e.entry_length = ALL_ONES - 64'($urandom_range(0, 32'h0010_0000));
        else if (p < 95)
            e.entry_length = REGION_BYTES;
        else
            e.entry_length = FOUR_GIB - e.entry_base;

        e.final_entry = last;
        return e;
    endfunction

    task automatic offer_entry(input t_entry e);
        int unsigned gap;
        gap = steady_run ? 0 : draw_gap();
        if (gap != 0) begin
            ent_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ent_if.valid <= 1'b1;
        ent_if.data  <= e;
        do @(posedge i_clk); while (!ent_if.ready);
        scan_check.note_entry(e);
        items_sent++;
        steady_run <= (items_sent % 250) < 50;
    endtask

    task automatic run_directed();
        // nothing available: zero window, region size reserved
        offer_entry(mk_entry(64'd0, 64'd0, KIND_RESERVED, 1'b1));
        // whole low 4 GiB
        offer_entry(mk_entry(64'd0, FOUR_GIB, AVAILABLE_CODE, 1'b1));
        // base above 4 GiB only counts toward the total; a zero length gives no window
        offer_entry(mk_entry(FOUR_GIB, ALL_ONES, AVAILABLE_CODE, 1'b0));
        offer_entry(mk_entry(64'h1000_0000, 64'd0, AVAILABLE_CODE, 1'b1));
        // wrapped end, base too high, end too low, alignment leaves nothing
        offer_entry(mk_entry(64'h8000_0000, ALL_ONES, AVAILABLE_CODE, 1'b0));
        offer_entry(mk_entry(64'hF900_0000, 64'h0100_0000, AVAILABLE_CODE, 1'b0));
        offer_entry(mk_entry(64'd0, 64'h0100_0000, AVAILABLE_CODE, 1'b0));
        offer_entry(mk_entry(64'h0810_0000, 64'h0010_0000, AVAILABLE_CODE, 1'b1));
        // equal and lower windows after a higher one are dropped
        offer_entry(mk_entry(64'h1000_0000, 64'h1000_0000, AVAILABLE_CODE, 1'b0));
        offer_entry(mk_entry(64'h0800_0000, 64'h1800_0000, AVAILABLE_CODE, 1'b0));
        offer_entry(mk_entry(64'h0400_0000, 64'h0800_0000, AVAILABLE_CODE, 1'b0));
        offer_entry(mk_entry(64'h4000_0000, 64'h1000_0000, KIND_MAX, 1'b1));
        // E801 words: below 16 MiB, at 16 MiB, above it
        offer_entry(mk_entry(64'h0040_0000, REGION_BYTES, AVAILABLE_CODE, 1'b1));
        offer_entry(mk_entry(64'h0100_0000, REGION_BYTES, AVAILABLE_CODE, 1'b1));
        offer_entry(mk_entry(64'h0140_0000, REGION_BYTES, AVAILABLE_CODE, 1'b1));
        // unaligned both ends, all-ones fields, total wrap
        offer_entry(mk_entry(64'h0012_3456, 64'h0C00_0000, AVAILABLE_CODE, 1'b0));
        offer_entry(mk_entry(ALL_ONES, ALL_ONES, AVAILABLE_CODE, 1'b0));
        offer_entry(mk_entry(64'd0, 64'd0, AVAILABLE_CODE, 1'b1));
        // base exactly at the highest allowed start
        offer_entry(mk_entry(64'hF800_0000, REGION_BYTES, AVAILABLE_CODE, 1'b1));
    endtask

    task automatic run_random();
        int unsigned sent;
        int unsigned scan_len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            scan_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                    : $urandom_range(1, 6);
            for (int unsigned k = 1; k <= scan_len; k++)
                offer_entry(rand_entry(k == scan_len));
            sent += scan_len;
        end
    endtask

    initial begin
        scan_check   = new();
        items_sent   = 0;
        steady_run   = 1'b0;
        i_rst_n      = 1'b0;
        ent_if.valid = 1'b0;
        ent_if.data  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random();
        ent_if.valid <= 1'b0;

        while (scan_check.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (scan_check.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Result side: check each transfer, stall at random, and once hold off long enough
    // for the block to back up into its input.
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned taken;
        bit          held_once;
        res_if.ready = 1'b0;
        stall_left   = 0;
        taken        = 0;
        held_once    = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                scan_check.check_result(res_if.data);
                taken++;
            end
            if (!held_once && taken == HOLD_AFTER) begin
                held_once  = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !steady_run && $urandom_range(0, 3) == 0)
                stall_left = draw_gap();
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else
                res_if.ready <= 1'b1;
        end
    end

endmodule
